[rtl/core/i2crm_pkg.sv]
package i2crm_pkg;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] REG_DEV_ADDR    = 2'd0;
    localparam logic [1:0] REG_PHASE_TICKS = 2'd1;
    localparam logic [1:0] REG_GUARD_TICKS = 2'd2;

    localparam logic [7:0]  DEV_ADDR_RESET    = 8'd112;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd50;
    localparam logic [15:0] GUARD_TICKS_RESET = 16'd1000;

    typedef struct packed {
        logic [7:0]  dev_addr;
        logic [15:0] phase_ticks;
        logic [15:0] guard_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       done;
        logic       busy;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } t_result;

endpackage

[rtl/core/i2crm_cfg.sv]
module i2crm_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output i2crm_pkg::t_cfg   o_cfg
);

    i2crm_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr    <= i2crm_pkg::DEV_ADDR_RESET;
            r_cfg.phase_ticks <= i2crm_pkg::PHASE_TICKS_RESET;
            r_cfg.guard_ticks <= i2crm_pkg::GUARD_TICKS_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                i2crm_pkg::REG_DEV_ADDR:    r_cfg.dev_addr    <= pwdata[7:0];
                i2crm_pkg::REG_PHASE_TICKS: r_cfg.phase_ticks <= pwdata[15:0];
                i2crm_pkg::REG_GUARD_TICKS: r_cfg.guard_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            i2crm_pkg::REG_DEV_ADDR:    prdata = {24'd0, r_cfg.dev_addr};
            i2crm_pkg::REG_PHASE_TICKS: prdata = {16'd0, r_cfg.phase_ticks};
            i2crm_pkg::REG_GUARD_TICKS: prdata = {16'd0, r_cfg.guard_ticks};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

[rtl/core/i2crm_ctrl.sv]
module i2crm_ctrl #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_reg_address,
    input  logic [7:0]           i_write_byte,
    input  logic                 i_sda_sample,
    input  i2crm_pkg::t_cfg      i_cfg,
    output i2crm_pkg::t_result   o_result
);

    localparam int TW = TICK_COUNT_WIDTH;
    localparam int CW = (TW + 1 > 17) ? TW + 1 : 17;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_START_C, PH_PRE, PH_SETUP,
        PH_HIGH, PH_LOW, PH_POST, PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_END,
        PH_RD_LOW, PH_RD_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_GUARD
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [TW-1:0]   r_tick_count, n_tick_count;
    logic [2:0]      r_bit_count, n_bit_count;
    logic [1:0]      r_byte_index, n_byte_index;
    logic [7:0]      r_shift_reg, n_shift_reg;
    logic [7:0]      r_read_reg, n_read_reg;
    logic            r_is_read, n_is_read;
    logic [7:0]      r_latched_reg, n_latched_reg;
    logic [7:0]      r_latched_data, n_latched_data;

    logic            start;
    t_phase          c_phase;
    logic [7:0]      c_shift;
    logic [1:0]      c_byte;
    logic            c_is_read;
    logic [7:0]      c_lreg;
    logic [7:0]      c_ldata;
    logic [TW-1:0]   c_tick;
    logic [15:0]     hold_raw;
    logic [15:0]     hold_nz;
    logic [CW-1:0]   tick_inc;
    logic            expire;
    logic            scl, sda, drv, done;

    assign start = (r_phase == PH_IDLE) &&
                   ((i_cmd == i2crm_pkg::CMD_WRITE) || (i_cmd == i2crm_pkg::CMD_READ));

    always_comb begin
        c_phase   = start ? PH_START_A : r_phase;
        c_shift   = start ? i_cfg.dev_addr : r_shift_reg;
        c_byte    = start ? 2'd0 : r_byte_index;
        c_is_read = start ? (i_cmd == i2crm_pkg::CMD_READ) : r_is_read;
        c_lreg    = start ? i_reg_address : r_latched_reg;
        c_ldata   = start ? i_write_byte : r_latched_data;
        c_tick    = start ? '0 : r_tick_count;
    end

    always_comb begin
        hold_raw = (c_phase == PH_GUARD) ? i_cfg.guard_ticks : i_cfg.phase_ticks;
        hold_nz  = (hold_raw == 16'd0) ? 16'd1 : hold_raw;
        tick_inc = {{(CW - TW){1'b0}}, c_tick} + CW'(1);
        expire   = tick_inc[TW] || (tick_inc >= {{(CW - 16){1'b0}}, hold_nz});
    end

    always_comb begin
        scl = 1'b1;
        sda = 1'b1;
        drv = 1'b1;
        case (c_phase)
            PH_START_A: scl = (c_byte == 2'd0);
            PH_START_C: sda = 1'b0;
            PH_PRE, PH_SETUP, PH_LOW, PH_POST: begin
                scl = 1'b0;
                sda = c_shift[7];
            end
            PH_HIGH: sda = c_shift[7];
            PH_ACK_LOW, PH_ACK_END, PH_RD_LOW: begin
                scl = 1'b0;
                drv = 1'b0;
            end
            PH_ACK_HIGH, PH_RD_HIGH: drv = 1'b0;
            PH_STOP_A: begin
                scl = 1'b0;
                sda = 1'b0;
            end
            PH_STOP_B: sda = 1'b0;
            default: ;
        endcase
    end

    always_comb begin
        n_phase        = c_phase;
        n_tick_count   = expire ? '0 : tick_inc[TW-1:0];
        n_bit_count    = start ? 3'd0 : r_bit_count;
        n_byte_index   = c_byte;
        n_shift_reg    = c_shift;
        n_read_reg     = r_read_reg;
        n_is_read      = c_is_read;
        n_latched_reg  = c_lreg;
        n_latched_data = c_ldata;
        done           = 1'b0;
        if (expire) begin
            unique case (c_phase)
                PH_START_A: n_phase = PH_START_B;
                PH_START_B: n_phase = PH_START_C;
                PH_START_C: begin
                    n_bit_count = 3'd0;
                    n_phase     = PH_PRE;
                end
                PH_PRE:     n_phase = PH_SETUP;
                PH_SETUP:   n_phase = PH_HIGH;
                PH_HIGH:    n_phase = PH_LOW;
                PH_LOW: begin
                    if (n_bit_count != 3'd7) begin
                        n_bit_count = n_bit_count + 3'd1;
                        n_shift_reg = {c_shift[6:0], 1'b0};
                        n_phase     = PH_SETUP;
                    end else begin
                        n_phase = PH_POST;
                    end
                end
                PH_POST:     n_phase = PH_ACK_LOW;
                PH_ACK_LOW:  n_phase = PH_ACK_HIGH;
                PH_ACK_HIGH: n_phase = PH_ACK_END;
                PH_ACK_END: begin
                    n_bit_count = 3'd0;
                    if (c_byte == 2'd0) begin
                        n_byte_index = 2'd1;
                        n_shift_reg  = c_lreg;
                        n_phase      = PH_PRE;
                    end else if (c_byte == 2'd1) begin
                        n_byte_index = 2'd2;
                        if (c_is_read) begin
                            n_shift_reg = i_cfg.dev_addr + 8'd1;
                            n_phase     = PH_START_A;
                        end else begin
                            n_shift_reg = c_ldata;
                            n_phase     = PH_PRE;
                        end
                    end else if (c_byte == 2'd2 && c_is_read) begin
                        n_byte_index = 2'd3;
                        n_shift_reg  = 8'd0;
                        n_phase      = PH_RD_LOW;
                    end else begin
                        n_phase = PH_STOP_A;
                    end
                end
                PH_RD_LOW: n_phase = PH_RD_HIGH;
                PH_RD_HIGH: begin
                    n_shift_reg = {c_shift[6:0], i_sda_sample};
                    if (n_bit_count != 3'd7) begin
                        n_bit_count = n_bit_count + 3'd1;
                        n_phase     = PH_RD_LOW;
                    end else begin
                        n_read_reg = n_shift_reg;
                        n_phase    = PH_STOP_A;
                    end
                end
                PH_STOP_A: n_phase = PH_STOP_B;
                PH_STOP_B: n_phase = PH_STOP_C;
                PH_STOP_C: begin
                    if (i_cfg.guard_ticks == 16'd0) begin
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_GUARD;
                    end
                end
                default: begin
                    done    = 1'b1;
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        if (c_phase == PH_IDLE) begin
            o_result.scl_level = 1'b1;
            o_result.sda_level = 1'b1;
            o_result.sda_drive = 1'b1;
            o_result.busy      = 1'b0;
            o_result.done      = 1'b0;
            o_result.read_byte = r_read_reg;
        end else begin
            o_result.scl_level = scl;
            o_result.sda_level = sda;
            o_result.sda_drive = drv;
            o_result.busy      = 1'b1;
            o_result.done      = done;
            o_result.read_byte = n_read_reg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_tick_count   <= '0;
            r_bit_count    <= 3'd0;
            r_byte_index   <= 2'd0;
            r_shift_reg    <= 8'd0;
            r_read_reg     <= 8'd0;
            r_is_read      <= 1'b0;
            r_latched_reg  <= 8'd0;
            r_latched_data <= 8'd0;
        end else if (i_step && (c_phase != PH_IDLE)) begin
            r_phase        <= n_phase;
            r_tick_count   <= n_tick_count;
            r_bit_count    <= n_bit_count;
            r_byte_index   <= n_byte_index;
            r_shift_reg    <= n_shift_reg;
            r_read_reg     <= n_read_reg;
            r_is_read      <= n_is_read;
            r_latched_reg  <= n_latched_reg;
            r_latched_data <= n_latched_data;
        end
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.done |-> o_result.busy)
        else $error("done without busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.done) |=> (r_phase == PH_IDLE))
        else $error("phase not idle after done");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick_count == '0))
        else $error("tick counter not cleared in idle");

    a_idle_sda: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_result.busy) |-> (o_result.sda_drive && o_result.sda_level && o_result.scl_level))
        else $error("bus not released while idle");

endmodule

[rtl/core/i2c_register_access_master.sv]
// I2C register access master. Each input transaction is one bus tick: the block takes one
// per clock and returns one result transaction per input, carrying the SCL/SDA levels, the
// SDA drive enable, busy, a done pulse and the last read byte. A command (tuser: 1 write,
// 2 read) is taken only on an idle tick and shows the start level on that same tick. Every
// bus level lasts phase_ticks ticks (0 acts as 1), the guard wait after stop guard_ticks,
// and a write runs 3 + 3*(1 + 8*3 + 4) + 3 = 93 levels, a read longer. Each result is
// registered and appears in the cycle after its tick is taken; input is taken whenever
// the result register is empty or being drained, so throughput is one tick per clock.
// Registers: 0x0 device write address, 0x4 phase ticks, 0x8 guard ticks.
module i2c_register_access_master #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] reg_address, [15:8] write_byte, [16] sda_sample, [23:17] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
    // [12:5] read_byte, [15:13] zero
    output logic [15:0] m_axis_tdata
);

    i2crm_pkg::t_cfg    cfg;
    i2crm_pkg::t_result result;
    i2crm_pkg::t_result r_result;
    logic               r_valid;
    logic               step;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {3'd0, r_result};

    i2crm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2crm_ctrl #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_cmd         (s_axis_tuser),
        .i_reg_address (s_axis_tdata[7:0]),
        .i_write_byte  (s_axis_tdata[15:8]),
        .i_sda_sample  (s_axis_tdata[16]),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= result;
        end
    end

endmodule

[bench/tb_i2c_register_access_master.sv]
module tb_i2c_register_access_master;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_TICKS = 1050;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 16;

    localparam i2crm_pkg::t_result LV_IDLE_00 = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    localparam i2crm_pkg::t_result LV_IDLE_FF = '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    localparam i2crm_pkg::t_result LV_START_00 = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

    typedef enum logic [4:0] {
        BP_IDLE, BP_START_A, BP_START_B, BP_START_C, BP_PRE, BP_SETUP,
        BP_HIGH, BP_LOW, BP_POST, BP_ACK_LOW, BP_ACK_HIGH, BP_ACK_END,
        BP_RD_LOW, BP_RD_HIGH, BP_STOP_A, BP_STOP_B, BP_STOP_C, BP_GUARD
    } t_bus_phase;

    typedef enum logic [1:0] {NO_FILL, FILL_LOW, FILL_HIGH, FILL_RANDOM} t_fill;

    typedef struct packed {
        logic               is_cfg;
        logic [1:0]         code;
        logic [15:0]        value;
        logic [7:0]         reg_addr;
        logic [7:0]         wr_byte;
        logic               sda;
        t_fill              fill;
        logic               typed;
        i2crm_pkg::t_result want;
    } t_drill_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] reg_address, [15:8] write_byte, [16] sda_sample, [23:17] zero
    logic [23:0] s_axis_tdata = '0;
    // [1:0] cmd
    logic [1:0]  s_axis_tuser = i2crm_pkg::CMD_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
    // [12:5] read_byte, [15:13] zero
    logic [15:0] m_axis_tdata;

    i2c_register_access_master u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    t_bus_phase bus_ph;
    logic [15:0] hold_cnt;
    logic [3:0]  bit_no;
    logic [2:0]  byte_no;
    logic [7:0]  out_shift;
    logic [7:0]  last_read;
    logic        txn_is_read;
    logic [7:0]  txn_reg;
    logic [7:0]  txn_data;
    logic [7:0]  cfg_dev;
    logic [15:0] cfg_phase;
    logic [15:0] cfg_guard;

    i2crm_pkg::t_result levels_q[$];
    i2crm_pkg::t_result seen_levels;
    i2crm_pkg::t_result owed_levels;
    int mismatches = 0;
    int quiet_cycles = 0;
    int burst_left = 1;
    int n_ticks = 0;
    int txn_left = 0;
    logic feeding = 1'b0;
    logic [15:0] rx_cyc = '0;
    t_drill_row drill [24];

    function automatic i2crm_pkg::t_result next_bus_levels(input logic [1:0] cmd,
                                                           input logic [7:0] reg_addr,
                                                           input logic [7:0] wr_byte,
                                                           input logic sda_in);
        i2crm_pkg::t_result r;
        logic [16:0] hold;
        logic bitv;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        r.sda_drive = 1'b1;
        r.busy = 1'b1;
        r.done = 1'b0;
        if (bus_ph == BP_IDLE) begin
            if (cmd == i2crm_pkg::CMD_WRITE || cmd == i2crm_pkg::CMD_READ) begin
                txn_is_read = (cmd == i2crm_pkg::CMD_READ);
                txn_reg = reg_addr;
                txn_data = wr_byte;
                out_shift = cfg_dev;
                byte_no = '0;
                bit_no = '0;
                hold_cnt = '0;
                bus_ph = BP_START_A;
            end else begin
                r.busy = 1'b0;
                r.read_byte = last_read;
                return r;
            end
        end
        bitv = out_shift[7];
        case (bus_ph)
            BP_START_A: r.scl_level = (byte_no == 3'd0);
            BP_START_B: ;
            BP_START_C: r.sda_level = 1'b0;
            BP_PRE, BP_SETUP, BP_LOW, BP_POST: begin
                r.scl_level = 1'b0;
                r.sda_level = bitv;
            end
            BP_HIGH: r.sda_level = bitv;
            BP_ACK_LOW, BP_ACK_END, BP_RD_LOW: begin
                r.scl_level = 1'b0;
                r.sda_drive = 1'b0;
            end
            BP_ACK_HIGH, BP_RD_HIGH: r.sda_drive = 1'b0;
            BP_STOP_A: begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b0;
            end
            BP_STOP_B: r.sda_level = 1'b0;
            default: ;
        endcase
        hold = {1'b0, (bus_ph == BP_GUARD) ? cfg_guard : cfg_phase};
        if (hold == 17'd0) hold = 17'd1;
        hold_cnt = hold_cnt + 16'd1;
        if (hold_cnt == 16'd0 || {1'b0, hold_cnt} >= hold) begin
            hold_cnt = '0;
            case (bus_ph)
                BP_START_A: bus_ph = BP_START_B;
                BP_START_B: bus_ph = BP_START_C;
                BP_START_C: begin
                    bit_no = '0;
                    bus_ph = BP_PRE;
                end
                BP_PRE: bus_ph = BP_SETUP;
                BP_SETUP: bus_ph = BP_HIGH;
                BP_HIGH: bus_ph = BP_LOW;
                BP_LOW: begin
                    if (bit_no < 4'd7) begin
                        bit_no = bit_no + 4'd1;
                        out_shift = {out_shift[6:0], 1'b0};
                        bus_ph = BP_SETUP;
                    end else begin
                        bus_ph = BP_POST;
                    end
                end
                BP_POST: bus_ph = BP_ACK_LOW;
                BP_ACK_LOW: bus_ph = BP_ACK_HIGH;
                BP_ACK_HIGH: bus_ph = BP_ACK_END;
                BP_ACK_END: begin
                    bit_no = '0;
                    if (byte_no == 3'd0) begin
                        byte_no = 3'd1;
                        out_shift = txn_reg;
                        bus_ph = BP_PRE;
                    end else if (byte_no == 3'd1) begin
                        byte_no = 3'd2;
                        if (txn_is_read) begin
                            out_shift = cfg_dev + 8'h01;
                            bus_ph = BP_START_A;
                        end else begin
                            out_shift = txn_data;
                            bus_ph = BP_PRE;
                        end
                    end else if (byte_no == 3'd2 && txn_is_read) begin
                        byte_no = 3'd3;
                        out_shift = '0;
                        bus_ph = BP_RD_LOW;
                    end else begin
                        bus_ph = BP_STOP_A;
                    end
                end
                BP_RD_LOW: bus_ph = BP_RD_HIGH;
                BP_RD_HIGH: begin
                    out_shift = {out_shift[6:0], sda_in};
                    if (bit_no < 4'd7) begin
                        bit_no = bit_no + 4'd1;
                        bus_ph = BP_RD_LOW;
                    end else begin
                        last_read = out_shift;
                        bus_ph = BP_STOP_A;
                    end
                end
                BP_STOP_A: bus_ph = BP_STOP_B;
                BP_STOP_B: bus_ph = BP_STOP_C;
                BP_STOP_C: begin
                    if (cfg_guard == 16'd0) begin
                        r.done = 1'b1;
                        bus_ph = BP_IDLE;
                    end else begin
                        bus_ph = BP_GUARD;
                    end
                end
                default: begin
                    r.done = 1'b1;
                    bus_ph = BP_IDLE;
                end
            endcase
        end
        r.read_byte = last_read;
        return r;
    endfunction

    function automatic t_drill_row cfg_row(input logic [1:0] idx, input logic [15:0] v);
        return '{1'b1, idx, v, 8'h00, 8'h00, 1'b0, NO_FILL, 1'b0, i2crm_pkg::t_result'(0)};
    endfunction

    function automatic t_drill_row tick_row(input logic [1:0] cmd, input logic [7:0] ra,
                                            input logic [7:0] wb, input logic sda,
                                            input t_fill fill, input logic typed,
                                            input i2crm_pkg::t_result want);
        return '{1'b0, cmd, 16'h0000, ra, wb, sda, fill, typed, want};
    endfunction

    task automatic tick(input logic [1:0] cmd, input logic [7:0] reg_addr,
                        input logic [7:0] wr_byte, input logic sda, input logic typed,
                        input i2crm_pkg::t_result want);
        i2crm_pkg::t_result pred;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {7'd0, sda, wr_byte, reg_addr};
        if (!feeding) begin
            s_axis_tvalid <= 1'b1;
            feeding = 1'b1;
        end
        do @(posedge i_clk); while (!s_axis_tready);
        pred = next_bus_levels(cmd, reg_addr, wr_byte, sda);
        levels_q.push_back(typed ? want : pred);
        n_ticks++;
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            feeding = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
    endtask

    task automatic run_to_idle(input t_fill fill, input logic noisy);
        logic sda;
        logic [1:0] cmd;
        while (bus_ph != BP_IDLE) begin
            case (fill)
                FILL_LOW: sda = 1'b0;
                FILL_HIGH: sda = 1'b1;
                default: sda = 1'($urandom_range(0, 1));
            endcase
            cmd = noisy ? 2'($urandom_range(0, 3)) : i2crm_pkg::CMD_NONE;
            tick(cmd, 8'($urandom), 8'($urandom), sda, 1'b0, i2crm_pkg::t_result'(0));
        end
    endtask

    task automatic settle();
        run_to_idle(FILL_RANDOM, 1'b0);
        if (feeding) begin
            s_axis_tvalid <= 1'b0;
            feeding = 1'b0;
        end
        while (levels_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] want;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            i2crm_pkg::REG_DEV_ADDR: cfg_dev = val[7:0];
            i2crm_pkg::REG_PHASE_TICKS: cfg_phase = val;
            default: cfg_guard = val;
        endcase
        want = (idx == i2crm_pkg::REG_DEV_ADDR) ? {24'd0, cfg_dev} : {16'd0, val};
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register 0x%0h readback: want %08h got %08h", {idx, 2'b00}, want,
                         prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reconfigure();
        if ($urandom_range(0, 3) != 0)
            reg_write(i2crm_pkg::REG_DEV_ADDR, 16'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0)
            reg_write(i2crm_pkg::REG_PHASE_TICKS,
                      ($urandom_range(0, 5) == 0) ? 16'($urandom_range(3, 5))
                                                  : 16'($urandom_range(0, 2)));
        if ($urandom_range(0, 3) != 0)
            reg_write(i2crm_pkg::REG_GUARD_TICKS,
                      ($urandom_range(0, 5) == 0) ? 16'($urandom_range(20, 60))
                                                  : 16'($urandom_range(0, 3)));
    endtask

    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 16'd1;
        case (rx_cyc[10:9])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_axis_tready <= (rx_cyc[1:0] == 2'd0);
            default: m_axis_tready <= (rx_cyc[4:0] < 5'd20);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_levels = i2crm_pkg::t_result'(m_axis_tdata[12:0]);
            if (levels_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: tdata %04h", m_axis_tdata);
            end else begin
                owed_levels = levels_q.pop_front();
                if (seen_levels !== owed_levels) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want scl=%b sda=%b drv=%b busy=%b done=%b rd=%02h,",
                                  " got scl=%b sda=%b drv=%b busy=%b done=%b rd=%02h"},
                                 owed_levels.scl_level, owed_levels.sda_level,
                                 owed_levels.sda_drive, owed_levels.busy, owed_levels.done,
                                 owed_levels.read_byte, seen_levels.scl_level,
                                 seen_levels.sda_level, seen_levels.sda_drive, seen_levels.busy,
                                 seen_levels.done, seen_levels.read_byte);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bus_ph = BP_IDLE;
        hold_cnt = '0;
        bit_no = '0;
        byte_no = '0;
        out_shift = '0;
        last_read = '0;
        txn_is_read = 1'b0;
        txn_reg = '0;
        txn_data = '0;
        cfg_dev = i2crm_pkg::DEV_ADDR_RESET;
        cfg_phase = i2crm_pkg::PHASE_TICKS_RESET;
        cfg_guard = i2crm_pkg::GUARD_TICKS_RESET;

        drill[0] = tick_row(i2crm_pkg::CMD_NONE, 8'h00, 8'h00, 1'b0, NO_FILL, 1'b1,
                            LV_IDLE_00);
        drill[1] = tick_row(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, NO_FILL, 1'b1, LV_IDLE_00);
        drill[2] = cfg_row(i2crm_pkg::REG_DEV_ADDR, 16'h00FF);
        drill[3] = cfg_row(i2crm_pkg::REG_PHASE_TICKS, 16'h0000);
        drill[4] = cfg_row(i2crm_pkg::REG_GUARD_TICKS, 16'h0000);
        drill[5] = tick_row(i2crm_pkg::CMD_WRITE, 8'h00, 8'hFF, 1'b0, NO_FILL, 1'b1,
                            LV_START_00);
        // a read arriving mid-write is dropped
        drill[6] = tick_row(i2crm_pkg::CMD_READ, 8'hFF, 8'h00, 1'b1, NO_FILL, 1'b0,
                            LV_IDLE_00);
        drill[7] = tick_row(i2crm_pkg::CMD_NONE, 8'h00, 8'h00, 1'b0, FILL_RANDOM, 1'b0,
                            LV_IDLE_00);
        drill[8] = tick_row(i2crm_pkg::CMD_READ, 8'hFF, 8'h5A, 1'b1, FILL_HIGH, 1'b0,
                            LV_IDLE_00);
        drill[9] = tick_row(i2crm_pkg::CMD_NONE, 8'h00, 8'h00, 1'b1, NO_FILL, 1'b1,
                            LV_IDLE_FF);
        drill[10] = tick_row(i2crm_pkg::CMD_READ, 8'h00, 8'h00, 1'b0, FILL_LOW, 1'b0,
                             LV_IDLE_00);
        drill[11] = tick_row(i2crm_pkg::CMD_NONE, 8'h00, 8'h00, 1'b0, NO_FILL, 1'b1,
                             LV_IDLE_00);
        drill[12] = cfg_row(i2crm_pkg::REG_DEV_ADDR, 16'h0000);
        drill[13] = cfg_row(i2crm_pkg::REG_PHASE_TICKS, 16'h0001);
        drill[14] = cfg_row(i2crm_pkg::REG_GUARD_TICKS, 16'h0003);
        drill[15] = tick_row(i2crm_pkg::CMD_WRITE, 8'hFF, 8'h00, 1'b1, FILL_RANDOM, 1'b0,
                             LV_IDLE_00);
        drill[16] = tick_row(i2crm_pkg::CMD_READ, 8'h80, 8'h01, 1'b0, FILL_RANDOM, 1'b0,
                             LV_IDLE_00);
        drill[17] = cfg_row(i2crm_pkg::REG_PHASE_TICKS, 16'hFFFF);
        drill[18] = cfg_row(i2crm_pkg::REG_GUARD_TICKS, 16'hFFFF);
        drill[19] = tick_row(i2crm_pkg::CMD_NONE, 8'h00, 8'h00, 1'b1, NO_FILL, 1'b0,
                             LV_IDLE_00);
        drill[20] = tick_row(CMD_UNUSED, 8'hAA, 8'h55, 1'b0, NO_FILL, 1'b0, LV_IDLE_00);
        drill[21] = cfg_row(i2crm_pkg::REG_PHASE_TICKS, 16'h0000);
        drill[22] = cfg_row(i2crm_pkg::REG_GUARD_TICKS, 16'h0000);
        drill[23] = tick_row(i2crm_pkg::CMD_WRITE, 8'h5A, 8'hA5, 1'b1, FILL_RANDOM, 1'b0,
                             LV_IDLE_00);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (drill[k]) begin
            if (drill[k].is_cfg) begin
                settle();
                reg_write(drill[k].code, drill[k].value);
            end else begin
                tick(drill[k].code, drill[k].reg_addr, drill[k].wr_byte, drill[k].sda,
                     drill[k].typed, drill[k].want);
                if (drill[k].fill != NO_FILL) run_to_idle(drill[k].fill, 1'b0);
            end
        end

        while (n_ticks < RANDOM_TICKS) begin
            if (txn_left == 0) begin
                settle();
                reconfigure();
                txn_left = $urandom_range(2, 4);
            end
            if ($urandom_range(0, 7) != 0) begin
                tick(2'($urandom_range(1, 2)), 8'($urandom), 8'($urandom),
                     1'($urandom_range(0, 1)), 1'b0, i2crm_pkg::t_result'(0));
                run_to_idle(FILL_RANDOM, 1'b1);
                txn_left--;
            end else begin
                repeat ($urandom_range(1, 5))
                    tick(($urandom_range(0, 1) != 0) ? CMD_UNUSED : i2crm_pkg::CMD_NONE,
                         8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                         i2crm_pkg::t_result'(0));
            end
        end

        if (feeding) begin
            s_axis_tvalid <= 1'b0;
            feeding = 1'b0;
        end
        while (levels_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/i2crm_pkg.sv
rtl/core/i2crm_cfg.sv
rtl/core/i2crm_ctrl.sv
rtl/core/i2c_register_access_master.sv
bench/tb_i2c_register_access_master.sv
